[sv/wav_pcm_header_parser_top_assert.svh]
// ----------------------------------------------------------------------------
// wav pcm header parser assertion macros
// concurrent checks clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef WAV_PCM_HEADER_PARSER_TOP_ASSERT_SVH
`define WAV_PCM_HEADER_PARSER_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define WPH_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wph assertion failed");

// consequent checked in the cycle after the antecedent
`define WPH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wph assertion failed");

`endif

[sv/wph_pkg.sv]
// ----------------------------------------------------------------------------
// wph_pkg
// shared widths, status codes and types of the wav pcm header parser
// ----------------------------------------------------------------------------
`default_nettype none

package wph_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int HALF_W   = 16;
   localparam int WORD_W   = 32;
   localparam int OFFSET_W = 17;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_RIFF  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_WAVE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_FMT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_PCM  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_DATA  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd6;
   localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd7;

   localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;

   localparam logic [WORD_W-1:0]   EXT_FMT_SIZE = 32'd18;
   localparam logic [OFFSET_W-1:0] BASE_OFFSET  = 17'd44;
   localparam logic [OFFSET_W-1:0] EXT_OFFSET   = 17'd46;
   localparam logic [HALF_W-1:0]   PCM_TAG      = 16'd1;

   typedef struct packed {
      logic busy;
      logic done;
   } wph_div_status_type;

endpackage

`default_nettype wire

[sv/wph_req_if.sv]
// ----------------------------------------------------------------------------
// wph_req_if
// byte stream channel into the parser, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface wph_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       starts_file;
   logic       ends_file;

   modport source (output valid, output data_byte, output starts_file, output ends_file,
                   input ready);
   modport sink   (input valid, input data_byte, input starts_file, input ends_file,
                   output ready);
endinterface

`default_nettype wire

[sv/wph_rsp_if.sv]
// ----------------------------------------------------------------------------
// wph_rsp_if
// header result channel out of the parser, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface wph_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] channel_count;
   logic [31:0] sample_rate;
   logic [31:0] byte_rate;
   logic [15:0] block_align;
   logic [15:0] bits_per_sample;
   logic [16:0] data_offset;
   logic [31:0] data_size;
   logic [31:0] frame_count;

   modport source (output valid, output status, output channel_count, output sample_rate,
                   output byte_rate, output block_align, output bits_per_sample,
                   output data_offset, output data_size, output frame_count,
                   input ready);
   modport sink   (input valid, input status, input channel_count, input sample_rate,
                   input byte_rate, input block_align, input bits_per_sample,
                   input data_offset, input data_size, input frame_count,
                   output ready);
endinterface

`default_nettype wire

[sv/wph_divider.sv]
// ----------------------------------------------------------------------------
// wph_divider
// restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit
// per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wph_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wph_pkg::WORD_W-1:0]  dividend,
   input  logic [wph_pkg::HALF_W-1:0]  divisor,
   output wph_pkg::wph_div_status_type status,
   output logic [wph_pkg::WORD_W-1:0]  quotient
);
   import wph_pkg::*;

   localparam int STEP_W = $clog2(WORD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

   logic              running_ff, running_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [HALF_W-1:0] rem_ff, rem_in;
   logic [HALF_W-1:0] dvs_ff, dvs_in;
   logic [HALF_W:0]   trial;
   logic [HALF_W:0]   diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      if (start) begin
         running_in = 1'b1;
         step_in    = '0;
         quo_in     = dividend;
         rem_in     = '0;
         dvs_in     = divisor;
      end else if (running_ff) begin
         rem_in  = fits ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
         quo_in  = {quo_ff[WORD_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign status.busy = running_ff | done_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

[sv/wav_pcm_header_parser_top.sv]
// results: a byte that fails a check or ends the file early gives its result in the next cycle
// a header that passes all checks gives its result once the frame count divide is done, via the divider's done register
// throughput: one byte per cycle; the 32-step divider for the frame count holds off input
// input also waits while a result is held and not taken
// reset: synchronous, parser returns to the riff tag with no result pending
// ----------------------------------------------------------------------------
// wav_pcm_header_parser_top
// byte-serial riff/wave pcm header parser with iterative frame count divide
// ----------------------------------------------------------------------------
`default_nettype none

`include "wav_pcm_header_parser_top_assert.svh"

module wav_pcm_header_parser_top (
   input logic      clock,
   input logic      reset,
   wph_req_if.sink  req_if,
   wph_rsp_if.source rsp_if
);
   import wph_pkg::*;

   localparam logic [3:0] PH_RIFF  = 4'd0;
   localparam logic [3:0] PH_RSIZE = 4'd1;
   localparam logic [3:0] PH_WAVE  = 4'd2;
   localparam logic [3:0] PH_FMT   = 4'd3;
   localparam logic [3:0] PH_FSIZE = 4'd4;
   localparam logic [3:0] PH_FTAG  = 4'd5;
   localparam logic [3:0] PH_CHAN  = 4'd6;
   localparam logic [3:0] PH_RATE  = 4'd7;
   localparam logic [3:0] PH_BRATE = 4'd8;
   localparam logic [3:0] PH_ALIGN = 4'd9;
   localparam logic [3:0] PH_BITS  = 4'd10;
   localparam logic [3:0] PH_EXT   = 4'd11;
   localparam logic [3:0] PH_SKIP  = 4'd12;
   localparam logic [3:0] PH_DTAG  = 4'd13;
   localparam logic [3:0] PH_DSIZE = 4'd14;

   // index of the last byte of each field
   function automatic logic [1:0] last_index(input logic [3:0] ph);
      logic [1:0] res;
      case (ph)
         PH_FTAG, PH_CHAN, PH_ALIGN, PH_BITS, PH_EXT: res = 2'd1;
         PH_SKIP:                                     res = 2'd0;
         default:                                     res = 2'd3;
      endcase
      return res;
   endfunction

   logic [3:0]          phase_ff, phase_in;
   logic [1:0]          idx_ff, idx_in;
   logic [WORD_W-1:0]   shift_ff, shift_in;
   logic                fmt18_ff, fmt18_in;
   logic [HALF_W-1:0]   chan_ff, chan_in;
   logic [WORD_W-1:0]   rate_ff, rate_in;
   logic [WORD_W-1:0]   brate_ff, brate_in;
   logic [HALF_W-1:0]   align_ff, align_in;
   logic [HALF_W-1:0]   bits_ff, bits_in;
   logic [HALF_W-1:0]   skip_ff, skip_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [WORD_W-1:0]   size_ff, size_in;
   logic                finished_ff, finished_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                req_ok;
   logic                starts;
   logic [3:0]          phase_e;
   logic [1:0]          idx_e;
   logic                finished_e;
   logic [WORD_W-1:0]   word_w;
   logic [HALF_W-1:0]   skip_dec;
   logic                emit;
   logic [STATUS_W-1:0] emit_status;
   logic                div_start;
   logic                status_ok;
   logic [WORD_W-1:0]   quotient;
   wph_div_status_type  div_st;

   assign req_ok = req_if.valid & req_if.ready;
   assign starts = req_if.starts_file;
   assign req_if.ready = ~div_st.busy & (~rsp_valid_ff | rsp_if.ready);

   always_comb begin
      phase_e    = starts ? PH_RIFF : phase_ff;
      if (phase_e > PH_DSIZE) begin
         phase_e = PH_RIFF;
      end
      idx_e      = starts ? 2'd0 : idx_ff;
      finished_e = starts ? 1'b0 : finished_ff;
      word_w     = (idx_e == 2'd0) ? {24'd0, req_if.data_byte}
                 : (shift_ff | ({24'd0, req_if.data_byte} << {idx_e, 3'b000}));
      skip_dec   = skip_ff - 1'b1;
   end

   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      shift_in    = shift_ff;
      fmt18_in    = fmt18_ff;
      chan_in     = chan_ff;
      rate_in     = rate_ff;
      brate_in    = brate_ff;
      align_in    = align_ff;
      bits_in     = bits_ff;
      skip_in     = skip_ff;
      offset_in   = offset_ff;
      size_in     = size_ff;
      finished_in = finished_ff;
      emit        = 1'b0;
      emit_status = ST_OK;
      div_start   = 1'b0;
      if (req_ok) begin
         phase_in    = phase_e;
         idx_in      = idx_e;
         finished_in = finished_e;
         if (starts) begin
            offset_in = BASE_OFFSET;
         end
         if (!finished_e) begin
            if (phase_e == PH_SKIP) begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_DTAG;
                  idx_in   = 2'd0;
               end
            end else begin
               shift_in = word_w;
               if (idx_e < last_index(phase_e)) begin
                  idx_in = idx_e + 1'b1;
               end else begin
                  idx_in = 2'd0;
                  case (phase_e)
                     PH_RIFF: begin
                        if (word_w != TAG_RIFF) begin
                           emit = 1'b1; emit_status = ST_NO_RIFF;
                        end
                        phase_in = PH_RSIZE;
                     end
                     PH_RSIZE: phase_in = PH_WAVE;
                     PH_WAVE: begin
                        if (word_w != TAG_WAVE) begin
                           emit = 1'b1; emit_status = ST_NO_WAVE;
                        end
                        phase_in = PH_FMT;
                     end
                     PH_FMT: begin
                        if (word_w != TAG_FMT) begin
                           emit = 1'b1; emit_status = ST_NO_FMT;
                        end
                        phase_in = PH_FSIZE;
                     end
                     PH_FSIZE: begin
                        fmt18_in = (word_w == EXT_FMT_SIZE);
                        phase_in = PH_FTAG;
                     end
                     PH_FTAG: begin
                        if (word_w[HALF_W-1:0] != PCM_TAG) begin
                           emit = 1'b1; emit_status = ST_NOT_PCM;
                        end
                        phase_in = PH_CHAN;
                     end
                     PH_CHAN: begin
                        chan_in  = word_w[HALF_W-1:0];
                        phase_in = PH_RATE;
                     end
                     PH_RATE: begin
                        rate_in  = word_w;
                        phase_in = PH_BRATE;
                     end
                     PH_BRATE: begin
                        brate_in = word_w;
                        phase_in = PH_ALIGN;
                     end
                     PH_ALIGN: begin
                        align_in = word_w[HALF_W-1:0];
                        phase_in = PH_BITS;
                     end
                     PH_BITS: begin
                        bits_in = word_w[HALF_W-1:0];
                        if (fmt18_ff) begin
                           phase_in = PH_EXT;
                        end else begin
                           offset_in = BASE_OFFSET;
                           phase_in  = PH_DTAG;
                        end
                     end
                     PH_EXT: begin
                        skip_in   = word_w[HALF_W-1:0];
                        offset_in = EXT_OFFSET + {1'b0, word_w[HALF_W-1:0]};
                        phase_in  = (word_w[HALF_W-1:0] != '0) ? PH_SKIP : PH_DTAG;
                     end
                     PH_DTAG: begin
                        if (word_w != TAG_DATA) begin
                           emit = 1'b1; emit_status = ST_NO_DATA;
                        end
                        phase_in = PH_DSIZE;
                     end
                     default: begin
                        size_in     = word_w;
                        finished_in = 1'b1;
                        if (align_ff == '0 || rate_ff == '0 || chan_ff == '0) begin
                           emit = 1'b1; emit_status = ST_ZERO;
                        end else begin
                           div_start = 1'b1;
                        end
                     end
                  endcase
               end
            end
            if (!emit && !div_start && req_if.ends_file) begin
               emit = 1'b1; emit_status = ST_TRUNC;
            end
            if (emit) begin
               finished_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
      end else if (div_st.done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RIFF;
         idx_ff       <= 2'd0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= BASE_OFFSET;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         offset_ff    <= offset_in;
      end
      shift_ff      <= shift_in;
      fmt18_ff      <= fmt18_in;
      chan_ff       <= chan_in;
      rate_ff       <= rate_in;
      brate_ff      <= brate_in;
      align_ff      <= align_in;
      bits_ff       <= bits_in;
      skip_ff       <= skip_in;
      size_ff       <= size_in;
      rsp_status_ff <= rsp_status_in;
   end

   wph_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (word_w),
      .divisor  (align_ff),
      .status   (div_st),
      .quotient (quotient)
   );

   // failed headers carry zero fields
   assign status_ok              = (rsp_status_ff == ST_OK);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.channel_count   = status_ok ? chan_ff   : '0;
   assign rsp_if.sample_rate     = status_ok ? rate_ff   : '0;
   assign rsp_if.byte_rate       = status_ok ? brate_ff  : '0;
   assign rsp_if.block_align     = status_ok ? align_ff  : '0;
   assign rsp_if.bits_per_sample = status_ok ? bits_ff   : '0;
   assign rsp_if.data_offset     = status_ok ? offset_ff : '0;
   assign rsp_if.data_size       = status_ok ? size_ff   : '0;
   assign rsp_if.frame_count     = status_ok ? quotient  : '0;

   `WPH_ASSERT_SAME(a_div_slot_free, div_st.done, !rsp_valid_ff)
   `WPH_ASSERT_NEXT(a_div_start_busy, div_start, finished_ff && div_st.busy)
   `WPH_ASSERT_SAME(a_fin_clear_on_start, $fell(finished_ff),
      $past(reset) || $past(req_ok && req_if.starts_file))

endmodule

`default_nettype wire
